/* rtl/core/sblit_pkg.sv */
// shared types and constants for the sprite blitter core
// no dependencies; imported by every module under rtl/core
package sblit_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_CLIP_ENABLE = 2'd0;
  localparam logic [1:0] CFG_CLIP_COLS   = 2'd1;
  localparam logic [1:0] CFG_CLIP_ROWS   = 2'd2;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    MODE_PASS       = 2'd0,
    MODE_RECOLOR    = 2'd1,
    MODE_SILHOUETTE = 2'd2
  } color_mode_e;

  typedef struct packed {
    logic       clip_enable;
    logic [7:0] clip_cols;
    logic [7:0] clip_rows;
  } cfg_t;

  // one source pixel as it leaves the counter stage
  typedef struct packed {
    logic [7:0]        dx;
    logic [7:0]        dy;
    logic [8:0]        width;      // 1..256
    logic signed [9:0] origin_x;
    logic signed [9:0] origin_y;
    logic [7:0]        color;
    logic signed [8:0] transp;
    logic              mirror;
    logic [1:0]        mode;
    logic [7:0]        target;
    logic [7:0]        repl;
  } stage_t;

endpackage

/* rtl/core/sblit_cnt.sv */
// input stage: column/row counters and the registered pixel beat
// depends on sblit_pkg
module sblit_cnt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              first_i,
  input  logic [sblit_pkg::IN_TDATA_W-1:0]  data_i,
  output logic                              st_valid_o,
  input  logic                              st_ready_i,
  output sblit_pkg::stage_t                 st_o
);
  import sblit_pkg::*;

  logic [7:0] col_q, col_d, row_q, row_d;
  logic [7:0] col_base, row_base;
  logic [8:0] width;
  logic       st_valid_q, st_valid_d;
  stage_t     st_q, st_d;
  logic       accept;

  assign in_ready_o = !st_valid_q || st_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_base = first_i ? 8'd0 : col_q;
    row_base = first_i ? 8'd0 : row_q;
    // zero width means a full 256 columns
    width = (data_i[27:20] == 8'd0) ? 9'd256 : {1'b0, data_i[27:20]};
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if ({1'b0, col_base} + 9'd1 >= width) begin
        col_d = 8'd0;
        row_d = row_base + 8'd1;
      end else begin
        col_d = col_base + 8'd1;
        row_d = row_base;
      end
    end
  end

  always_comb begin
    st_d          = st_q;
    st_valid_d    = st_valid_q;
    if (accept) begin
      st_valid_d  = 1'b1;
      st_d.dx       = col_base;
      st_d.dy       = row_base;
      st_d.width    = width;
      st_d.origin_x = data_i[9:0];
      st_d.origin_y = data_i[19:10];
      st_d.color    = data_i[35:28];
      st_d.transp   = data_i[44:36];
      st_d.mirror   = data_i[45];
      st_d.mode     = data_i[47:46];
      st_d.target   = data_i[55:48];
      st_d.repl     = data_i[63:56];
    end else if (st_ready_i) begin
      st_valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= 8'd0;
      row_q      <= 8'd0;
      st_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_valid_o = st_valid_q;
  assign st_o       = st_q;

endmodule

/* rtl/core/sblit_pix.sv */
// placement, clip, transparency and recolor, then the output register
// depends on sblit_pkg
module sblit_pix #(
  parameter int unsigned SCREEN_WIDTH  = 110,
  parameter int unsigned SCREEN_HEIGHT = 88
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sblit_pkg::cfg_t                   cfg_i,
  input  logic                              st_valid_i,
  output logic                              st_ready_o,
  input  sblit_pkg::stage_t                 st_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sblit_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import sblit_pkg::*;

  localparam logic signed [11:0] ScrW = 12'(SCREEN_WIDTH);
  localparam logic signed [11:0] ScrH = 12'(SCREEN_HEIGHT);

  logic [8:0]         offset;
  logic signed [11:0] px, py;
  logic               keep;
  logic [7:0]         color;
  logic               out_valid_q, out_valid_d;
  logic [6:0]         px_q, py_q;
  logic [7:0]         color_q;
  logic               load;

  always_comb begin
    if (st_i.mirror) begin
      offset = st_i.width - 9'd1 - (({1'b0, st_i.dx} < st_i.width) ? {1'b0, st_i.dx} : 9'd0);
    end else begin
      offset = {1'b0, st_i.dx};
    end
    px = 12'(st_i.origin_x) + $signed({3'b000, offset});
    py = 12'(st_i.origin_y) + $signed({4'b0000, st_i.dy});

    keep = 1'b1;
    if ({1'b0, st_i.dx} >= st_i.width) keep = 1'b0;
    if (cfg_i.clip_enable &&
        (st_i.dx >= cfg_i.clip_cols || st_i.dy >= cfg_i.clip_rows)) keep = 1'b0;
    if (px < 12'sd0 || py < 12'sd0 || px >= ScrW || py >= ScrH) keep = 1'b0;
    // negative transparent index disables transparency
    if (!st_i.transp[8] && st_i.transp[7:0] == st_i.color) keep = 1'b0;

    case (color_mode_e'(st_i.mode))
      MODE_RECOLOR:    color = (st_i.color == st_i.target) ? st_i.repl : st_i.color;
      MODE_SILHOUETTE: color = st_i.repl;
      default:         color = st_i.color;
    endcase
  end

  assign st_ready_o = !out_valid_q || out_ready_i;
  assign load       = st_valid_i && st_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = keep;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q    <= px[6:0];
      py_q    <= py[6:0];
      color_q <= color;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, color_q, py_q, px_q};

endmodule

/* rtl/core/sprite_blitter_core.sv */
// sprite blitter core: top level joining the counter stage and pixel stage
// depends on sblit_pkg, sblit_cnt, sblit_pix
//
// usage:
//   s_axis carries one source pixel per beat in raster order; tuser marks
//   the first pixel of a sprite and restarts the column and row counters.
//   m_axis carries one frame buffer write per kept pixel; pixels that are
//   clipped, off screen or transparent produce no beat.
//   cfg_* writes clip enable (0), clip columns (1), clip rows (2); write it
//   only while the core is idle. cfg_ready_o is always high.
// pipeline and throughput:
//   a kept pixel reaches m_axis through the counter register, then the output
//   register. one pixel per cycle is sustained while m_axis_tready is high,
//   since each stage is a counter update or a handful of adds and compares.
// reset:
//   counters, clip registers and both valid flags clear.
// stall:
//   when m_axis_tready is low the output register holds, the counter stage
//   still takes one more beat if it is empty, and then s_axis_tready drops.
module sprite_blitter_core #(
  parameter int unsigned SCREEN_WIDTH  = 110,
  parameter int unsigned SCREEN_HEIGHT = 88
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // origin_x, origin_y, sprite_width, pixel_color, key color,
  // mirror, color_mode, recolor source, recolor value
  input  logic [sblit_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // first_pixel
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_x, pixel_y, out_color, zero pad
  output logic [sblit_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [7:0]                         cfg_data_i
);
  import sblit_pkg::*;

  cfg_t   cfg_q, cfg_d;
  stage_t st;
  logic   st_valid, st_ready;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLIP_ENABLE: cfg_d.clip_enable = cfg_data_i[0];
        CFG_CLIP_COLS:   cfg_d.clip_cols   = cfg_data_i;
        CFG_CLIP_ROWS:   cfg_d.clip_rows   = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sblit_cnt u_cnt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .first_i    (s_axis_tuser),
    .data_i     (s_axis_tdata),
    .st_valid_o (st_valid),
    .st_ready_i (st_ready),
    .st_o       (st)
  );

  sblit_pix #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_pix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .st_valid_i  (st_valid),
    .st_ready_o  (st_ready),
    .st_i        (st),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* bench/sprite_blitter_core_test.sv */
`timescale 1ns / 1ps
// self-checking bench for sprite_blitter_core: directed pixel table, then random sprites
// under several clip settings; depends on sblit_pkg and the sprite_blitter_core rtl
module sprite_blitter_core_test;
  import sblit_pkg::*;

  localparam int SCREEN_W       = 110;
  localparam int SCREEN_H       = 88;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 55;
  localparam int NUM_PHASES     = 6;
  localparam int NO_KEY         = -1;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef struct packed {
    logic signed [9:0] origin_x;
    logic signed [9:0] origin_y;
    logic [7:0]        sprite_width;
    logic [7:0]        pixel_color;
    logic signed [8:0] key_color;
    logic              mirror;
    logic [1:0]        color_mode;
    logic [7:0]        recolor_from;
    logic [7:0]        recolor_to;
  } src_pixel_t;

  // same layout as m_axis_tdata, lowest field last
  typedef struct packed {
    logic [1:0] pad;
    logic [7:0] color;
    logic [6:0] y;
    logic [6:0] x;
  } fb_write_t;

  typedef struct {
    logic       first;
    src_pixel_t pix;
    bit         listed;
    bit         kept;
    fb_write_t  write;
  } pixel_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i;
  logic [7:0]             cfg_data_i;

  // predictor state
  logic       clip_on;
  logic [7:0] clip_cols;
  logic [7:0] clip_rows;
  logic [7:0] sprite_col;
  logic [7:0] sprite_row;

  fb_write_t  expected_writes[$];
  pixel_row_t pixel_table[$];
  fb_write_t  seen_write;
  fb_write_t  want_write;
  int         fail_count = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         items_fed = 0;
  int         rx_tick = 0;
  int         rx_style = 0;

  sprite_blitter_core #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // place one source pixel; returns 1 when it lands on the frame buffer
  function automatic bit blit_pixel(input logic first, input src_pixel_t p,
                                    output fb_write_t w);
    int span, dx, dy, px, py, key;
    bit kept;
    logic [7:0] color;
    span = (p.sprite_width == 8'd0) ? 256 : int'(p.sprite_width);
    if (first) begin
      sprite_col = '0;
      sprite_row = '0;
    end
    dx = int'(sprite_col);
    dy = int'(sprite_row);
    if (dx + 1 >= span) begin
      sprite_col = '0;
      sprite_row = sprite_row + 8'd1;
    end else begin
      sprite_col = 8'(dx + 1);
    end
    // a column past a narrowed width is dropped
    kept = (dx < span);
    if (clip_on && (dx >= int'(clip_cols) || dy >= int'(clip_rows))) kept = 1'b0;
    if (p.mirror) px = int'($signed(p.origin_x)) + span - 1 - ((dx < span) ? dx : 0);
    else px = int'($signed(p.origin_x)) + dx;
    py = int'($signed(p.origin_y)) + dy;
    if (px < 0 || py < 0 || px >= SCREEN_W || py >= SCREEN_H) kept = 1'b0;
    key = int'($signed(p.key_color));
    if (key >= 0 && key == int'(p.pixel_color)) kept = 1'b0;
    color = p.pixel_color;
    if (p.color_mode == MODE_RECOLOR && color == p.recolor_from) color = p.recolor_to;
    else if (p.color_mode == MODE_SILHOUETTE) color = p.recolor_to;
    w.pad   = '0;
    w.x     = px[6:0];
    w.y     = py[6:0];
    w.color = color;
    return kept;
  endfunction

  // send one pixel beat, with bursty pacing; the expectation comes from the
  // predictor unless the row lists it
  task automatic feed_pixel(input logic first, input src_pixel_t p, input bit listed,
                            input bit listed_kept, input fb_write_t listed_write);
    fb_write_t w;
    bit kept;
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= first;
    s_axis_tdata  <= {p.recolor_to, p.recolor_from, p.color_mode, p.mirror,
                      p.key_color, p.pixel_color, p.sprite_width,
                      p.origin_y, p.origin_x};
    do @(posedge clk_i); while (!s_axis_tready);
    items_fed++;
    kept = blit_pixel(first, p, w);
    if (listed) begin
      kept = listed_kept;
      w    = listed_write;
    end
    if (kept) expected_writes.insert(expected_writes.size(), w);
  endtask

  task automatic add_row(input int first, input int ox, input int oy, input int span,
                         input int color, input int key, input int mir,
                         input logic [1:0] mode, input int tgt, input int rep,
                         input int listed, input int kept, input int x, input int y,
                         input int c);
    pixel_row_t r;
    r.first            = 1'(first);
    r.pix.origin_x     = 10'(ox);
    r.pix.origin_y     = 10'(oy);
    r.pix.sprite_width = 8'(span);
    r.pix.pixel_color  = 8'(color);
    r.pix.key_color    = 9'(key);
    r.pix.mirror       = 1'(mir);
    r.pix.color_mode   = mode;
    r.pix.recolor_from = 8'(tgt);
    r.pix.recolor_to   = 8'(rep);
    r.listed           = 1'(listed);
    r.kept             = 1'(kept);
    r.write.pad        = '0;
    r.write.x          = 7'(x);
    r.write.y          = 7'(y);
    r.write.color      = 8'(c);
    pixel_table.insert(pixel_table.size(), r);
  endtask

  // hold the stream and let every pending write and any dropped pixel drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CLIP_ENABLE: clip_on   = val[0];
      CFG_CLIP_COLS:   clip_cols = val;
      CFG_CLIP_ROWS:   clip_rows = val;
      default: ;
    endcase
  endtask

  task automatic set_clip(input logic en, input logic [7:0] cols, input logic [7:0] rows);
    settle();
    write_reg(CFG_CLIP_ENABLE, {7'd0, en});
    write_reg(CFG_CLIP_COLS, cols);
    write_reg(CFG_CLIP_ROWS, rows);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly whole sprites with random content; a few flipped first flags and
  // widths changed mid-sprite
  task automatic blit_random_sprite();
    src_pixel_t p;
    int pick, span, n_pix;
    logic first;
    pick = $urandom_range(0, 9);
    if (pick == 0) p.sprite_width = 8'd0;
    else if (pick == 1) p.sprite_width = 8'd255;
    else if (pick == 2) p.sprite_width = 8'($urandom_range(1, 255));
    else p.sprite_width = 8'($urandom_range(1, 12));
    span = (p.sprite_width == 8'd0) ? 256 : int'(p.sprite_width);
    n_pix = span * $urandom_range(1, 6);
    if (n_pix > 40) n_pix = $urandom_range(1, 40);
    if ($urandom_range(0, 3) == 0) begin
      p.origin_x = 10'($urandom);
      p.origin_y = 10'($urandom);
    end else begin
      p.origin_x = 10'($urandom_range(0, 131) - 16);
      p.origin_y = 10'($urandom_range(0, 107) - 16);
    end
    p.key_color    = $urandom_range(0, 1) ? 9'(NO_KEY) : {1'b0, 8'($urandom)};
    p.mirror       = 1'($urandom);
    p.color_mode   = 2'($urandom);
    p.recolor_from = 8'($urandom);
    p.recolor_to   = 8'($urandom);
    for (int i = 0; i < n_pix; i++) begin
      first = (i == 0);
      case ($urandom_range(0, 3))
        0:       p.pixel_color = p.key_color[7:0];
        1:       p.pixel_color = p.recolor_from;
        default: p.pixel_color = 8'($urandom);
      endcase
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1)) first = ~first;
        else p.sprite_width = 8'($urandom);
      end
      feed_pixel(first, p, 1'b0, 1'b0, '0);
    end
  endtask

  // output check and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_write = fb_write_t'(m_axis_tdata);
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write x=%0d y=%0d color=%02h pad=%0d", $time,
                 seen_write.x, seen_write.y, seen_write.color, seen_write.pad);
        fail_count++;
      end else begin
        want_write = expected_writes[0];
        expected_writes.delete(0);
        if (seen_write !== want_write) begin
          $display("%0t: expected x=%0d y=%0d color=%02h pad=%0d, got x=%0d y=%0d color=%02h pad=%0d",
                   $time, want_write.x, want_write.y, want_write.color, want_write.pad,
                   seen_write.x, seen_write.y, seen_write.color, seen_write.pad);
          fail_count++;
        end
      end
    end
    rx_tick++;
    if (rx_tick % 64 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((rx_tick % 16) < 5);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("sprite_blitter_core: mismatch");
      $finish;
    end
  end

  initial begin
    int start;
    logic en;
    logic [7:0] cols, rows;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_CLIP_ENABLE;
    cfg_data_i    = '0;
    clip_on       = 1'b0;
    clip_cols     = '0;
    clip_rows     = '0;
    sprite_col    = '0;
    sprite_row    = '0;

    // first  ox    oy    w    color key     mir  mode             tgt    rep  lst kept x  y  c
    add_row(1,    0,    0,   4, 'h11, NO_KEY, 0, MODE_PASS,       0,     0, 1, 1, 0, 0, 'h11);
    add_row(0,    0,    0,   4, 'h12, NO_KEY, 0, MODE_PASS,       0,     0, 1, 1, 1, 0, 'h12);
    add_row(0,    0,    0,   4, 'h22, 'h022, 0, MODE_PASS,       0,     0, 1, 0, 0, 0, 0);
    add_row(0,    0,    0,   4, 'h33, NO_KEY, 1, MODE_PASS,       0,     0, 0, 0, 0, 0, 0);
    add_row(0,    0,    0,   4, 'h44, NO_KEY, 0, MODE_RECOLOR, 'h44, 'hAA, 0, 0, 0, 0, 0);
    add_row(0,    0,    0,   4, 'h45, NO_KEY, 0, MODE_RECOLOR, 'h44, 'hAA, 0, 0, 0, 0, 0);
    add_row(0,    0,    0,   4, 'h00, NO_KEY, 0, MODE_SILHOUETTE,  0, 'hFF, 0, 0, 0, 0, 0);
    add_row(0,    0,    0,   4, 'hFF, NO_KEY, 0, MODE_RESERVED, 'hFF,    0, 0, 0, 0, 0, 0);
    // origin extremes and screen edges
    add_row(1, -512, -512, 255,    0, NO_KEY, 0, MODE_PASS,       0,     0, 1, 0, 0, 0, 0);
    add_row(1,  511,  511, 255,    0, NO_KEY, 0, MODE_PASS,       0,     0, 1, 0, 0, 0, 0);
    add_row(1,  109,   87,   1, 'hFF, NO_KEY, 0, MODE_PASS,       0,     0, 1, 1, 109, 87, 'hFF);
    add_row(1,  110,    0,   1, 'h01, NO_KEY, 0, MODE_PASS,       0,     0, 1, 0, 0, 0, 0);
    add_row(1,    0,   88,   1, 'h01, NO_KEY, 0, MODE_PASS,       0,     0, 1, 0, 0, 0, 0);
    // zero width means 256 columns, mirrored
    add_row(1, -255,    0,   0, 'h05, NO_KEY, 1, MODE_PASS,       0,     0, 0, 0, 0, 0, 0);
    add_row(0, -255,    0,   0, 'h05, NO_KEY, 1, MODE_PASS,       0,     0, 0, 0, 0, 0, 0);
    add_row(1,    0,    0, 255, 'hFF, 'h0FF, 0, MODE_PASS,       0,     0, 1, 0, 0, 0, 0);
    // width narrowed inside a sprite drops the stray column
    add_row(1,   10,   10,  10, 'h01, NO_KEY, 0, MODE_PASS,       0,     0, 0, 0, 0, 0, 0);
    add_row(0,   10,   10,  10, 'h02, NO_KEY, 0, MODE_PASS,       0,     0, 0, 0, 0, 0, 0);
    add_row(0,   10,   10,  10, 'h03, NO_KEY, 0, MODE_PASS,       0,     0, 0, 0, 0, 0, 0);
    add_row(0,   10,   10,   2, 'h04, NO_KEY, 0, MODE_PASS,       0,     0, 0, 0, 0, 0, 0);
    add_row(0,   10,   10,   2, 'h05, NO_KEY, 0, MODE_PASS,       0,     0, 0, 0, 0, 0, 0);
    add_row(0,   -1,   10,   2, 'hFF, NO_KEY, 0, MODE_RECOLOR, 'hFF, 'hFF, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pixel_table[i]) begin
      feed_pixel(pixel_table[i].first, pixel_table[i].pix, pixel_table[i].listed,
                 pixel_table[i].kept, pixel_table[i].write);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin en = 1'b1; cols = 8'd0;   rows = 8'd0;   end  // empty clip box
        1: begin en = 1'b1; cols = 8'd255; rows = 8'd255; end
        2: begin en = 1'b1; cols = 8'd4;   rows = 8'd3;   end
        3: begin en = 1'b0; cols = 8'($urandom); rows = 8'($urandom); end
        4: begin
          en   = 1'b1;
          cols = 8'($urandom_range(1, 20));
          rows = 8'($urandom_range(1, 20));
        end
        default: begin en = 1'b1; cols = 8'd255; rows = 8'd1; end
      endcase
      set_clip(en, cols, rows);
      start = items_fed;
      while (items_fed - start < PHASE_ITEMS) blit_random_sprite();
    end

    settle();
    if (fail_count == 0) begin
      $display("sprite_blitter_core: match");
    end else begin
      $display("sprite_blitter_core: mismatch");
    end
    $finish;
  end

endmodule

/* sprite_blitter_core.f */
rtl/core/sblit_pkg.sv
rtl/core/sblit_cnt.sv
rtl/core/sblit_pix.sv
rtl/core/sprite_blitter_core.sv
bench/sprite_blitter_core_test.sv
